// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl modules, included by the control unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/sfcb_pkg.sv =====
// types, codes and constants of the serial flow control buffer engine
`timescale 1ns / 1ps

package sfcb_pkg;

  // default ring depths
  localparam int RX_DEPTH_DEF = 256;
  localparam int TX_DEPTH_DEF = 512;

  // flow control characters
  localparam logic [7:0] CH_XON  = 8'd17;
  localparam logic [7:0] CH_XOFF = 8'd19;

  // register reset values
  localparam logic [1:0]  FLOW_MODE_RST   = 2'd0;
  localparam logic [8:0]  RX_CAPACITY_RST = 9'd192;
  localparam logic [7:0]  RX_RESERVE_RST  = 8'd64;
  localparam logic [15:0] IDLE_LIMIT_RST  = 16'd100;

  // flow modes, the fourth code behaves as no flow control
  localparam logic [1:0] FLOW_NONE     = 2'd0;
  localparam logic [1:0] FLOW_RTS_CTS  = 2'd1;
  localparam logic [1:0] FLOW_XON_XOFF = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_FLOW_MODE   = 2'd0;
  localparam logic [1:0] CFG_RX_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_RX_RESERVE  = 2'd2;
  localparam logic [1:0] CFG_IDLE_LIMIT  = 2'd3;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_POLL   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_RUNNING  = 3'd0,
    ST_NO_ACT   = 3'd1,
    ST_FULL     = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_ACCEPTED = 3'd4,
    ST_REJECTED = 3'd5,
    ST_IGNORED  = 3'd6
  } status_t;

  // result word held in the output register of the control unit
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rts;
    status_t     status;
    logic        sel_tx;
    logic        sel_rx;
    logic [8:0]  rx_level;
    logic [9:0]  tx_level;
  } result_t;

endpackage

// ===== rtl/sfcb_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module sfcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sfcb_ctrl.sv =====
// control unit: ring pointers, session and flow state, output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfcb_ctrl #(
  parameter int RX_DEPTH = sfcb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = sfcb_pkg::TX_DEPTH_DEF,
  localparam int RIW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1,
  localparam int TIW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [7:0]           data_byte,
  input  logic                 rx_ready,
  input  logic                 tx_empty,
  input  logic                 cts_level,
  // output register
  output logic                 out_valid,
  input  logic                 out_stall,
  output sfcb_pkg::result_t    res,
  // receive ring memory
  output logic                 rx_we,
  output logic [RIW-1:0]       rx_waddr,
  output logic                 rx_re,
  output logic [RIW-1:0]       rx_raddr,
  // transmit ring memory
  output logic                 tx_we,
  output logic [TIW-1:0]       tx_waddr,
  output logic                 tx_re,
  output logic [TIW-1:0]       tx_raddr
);

  localparam int RFW = $clog2(RX_DEPTH + 1);
  localparam int TFW = $clog2(TX_DEPTH + 1);
  localparam int CW  = (RFW > 9) ? RFW : 9;

  typedef enum logic [1:0] {PH_NONE, PH_POLL, PH_DRAIN} phase_t;
  typedef enum logic [1:0] {PEND_NONE, PEND_XON, PEND_XOFF} pend_t;

  // configuration registers
  logic [1:0]  flow_mode;
  logic [8:0]  rx_capacity;
  logic [7:0]  rx_reserve;
  logic [15:0] idle_limit;

  // control state
  logic [RIW-1:0] rx_wr, rx_wr_next, rx_rd, rx_rd_next;
  logic [RFW-1:0] rx_fill, rx_fill_next;
  logic [TIW-1:0] tx_wr, tx_wr_next, tx_rd, tx_rd_next;
  logic [TFW-1:0] tx_fill, tx_fill_next;
  logic           partner_ok, partner_ok_next;
  logic           rx_allowed, rx_allowed_next;
  logic           rts_flag, rts_flag_next;
  phase_t         phase, phase_next;
  logic [15:0]    idle_count, idle_count_next;
  pend_t          pending, pending_next;

  sfcb_pkg::result_t res_next;
  logic              in_acc;

  // receive limits
  logic [CW-1:0] cap_ext, cap, cap_m1, rsv_ext, rsv, hw, fill_ext, fill_put_ext;

  // per-sample helpers
  logic           mode_rts, mode_xon, able, send_try, ctrl_char, do_put;
  logic [RFW-1:0] fill_put;
  logic [15:0]    idle_base, idle_inc;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign mode_rts  = (flow_mode == sfcb_pkg::FLOW_RTS_CTS);
  assign mode_xon  = (flow_mode == sfcb_pkg::FLOW_XON_XOFF);
  assign ctrl_char = mode_xon && ((data_byte == sfcb_pkg::CH_XON) ||
                                  (data_byte == sfcb_pkg::CH_XOFF));

  // capacity forced to 1..depth, reserve clamped, high-water mark
  always_comb begin
    cap_ext = CW'(rx_capacity);
    if (cap_ext == '0) begin
      cap = CW'(1);
    end else if (cap_ext > CW'(RX_DEPTH)) begin
      cap = CW'(RX_DEPTH);
    end else begin
      cap = cap_ext;
    end
    cap_m1  = cap - CW'(1);
    rsv_ext = CW'(rx_reserve);
    rsv     = (rsv_ext > cap_m1) ? cap_m1 : rsv_ext;
    hw      = cap - rsv;
  end

  assign fill_ext     = CW'(rx_fill);
  assign do_put       = (fill_ext < cap);
  assign fill_put     = do_put ? rx_fill + RFW'(1) : rx_fill;
  assign fill_put_ext = CW'(fill_put);

  // send permission and idle counting for a polling sample
  always_comb begin
    case (flow_mode)
      sfcb_pkg::FLOW_RTS_CTS:  able = cts_level;
      sfcb_pkg::FLOW_XON_XOFF: able = partner_ok;
      default:                 able = 1'b1;
    endcase
  end
  assign send_try  = (phase == PH_POLL) && able && (tx_fill != '0);
  assign idle_base = send_try ? 16'd0 : idle_count;
  assign idle_inc  = idle_base + 16'd1;

  // next state for one accepted word
  always_comb begin
    rx_wr_next      = rx_wr;
    rx_rd_next      = rx_rd;
    rx_fill_next    = rx_fill;
    tx_wr_next      = tx_wr;
    tx_rd_next      = tx_rd;
    tx_fill_next    = tx_fill;
    partner_ok_next = partner_ok;
    rx_allowed_next = rx_allowed;
    rts_flag_next   = rts_flag;
    phase_next      = phase;
    idle_count_next = idle_count;
    pending_next    = pending;
    rx_we           = 1'b0;
    rx_re           = 1'b0;
    tx_we           = 1'b0;
    tx_re           = 1'b0;
    rx_waddr        = rx_wr;
    rx_raddr        = rx_rd;
    tx_waddr        = tx_wr;
    tx_raddr        = tx_rd;
    res_next        = '0;
    res_next.status = sfcb_pkg::ST_IGNORED;

    case (sfcb_pkg::cmd_t'(command))
      // host queues a transmit byte
      sfcb_pkg::CMD_PUSH: begin
        if (tx_fill == TFW'(TX_DEPTH)) begin
          res_next.status = sfcb_pkg::ST_REJECTED;
        end else begin
          tx_we           = 1'b1;
          tx_wr_next      = (tx_wr == TIW'(TX_DEPTH - 1)) ? '0 : tx_wr + TIW'(1);
          tx_fill_next    = tx_fill + TFW'(1);
          res_next.status = sfcb_pkg::ST_ACCEPTED;
        end
      end
      // host takes a received byte
      sfcb_pkg::CMD_POP: begin
        if (rx_fill == '0) begin
          res_next.status = sfcb_pkg::ST_REJECTED;
        end else begin
          rx_re           = 1'b1;
          res_next.sel_rx = 1'b1;
          rx_rd_next      = (rx_rd == RIW'(RX_DEPTH - 1)) ? '0 : rx_rd + RIW'(1);
          rx_fill_next    = rx_fill - RFW'(1);
          res_next.status = sfcb_pkg::ST_ACCEPTED;
        end
      end
      // start a poll session
      sfcb_pkg::CMD_POLL: begin
        phase_next = PH_NONE;
        if (fill_ext >= hw) begin
          res_next.status = (fill_ext >= cap) ? sfcb_pkg::ST_OVERFLOW : sfcb_pkg::ST_FULL;
        end else begin
          if (mode_rts) begin
            rts_flag_next = 1'b1;
          end else if (mode_xon && !rx_allowed) begin
            pending_next    = PEND_XON;
            rx_allowed_next = 1'b1;
          end
          phase_next      = PH_POLL;
          idle_count_next = 16'd0;
          res_next.status = sfcb_pkg::ST_RUNNING;
        end
      end
      // line sample
      default: begin
        if (pending != PEND_NONE) begin
          if (tx_empty) begin
            res_next.tx_valid = 1'b1;
            res_next.tx_byte  = (pending == PEND_XON) ? sfcb_pkg::CH_XON : sfcb_pkg::CH_XOFF;
            pending_next      = PEND_NONE;
          end
          res_next.status = (phase != PH_NONE) ? sfcb_pkg::ST_RUNNING : sfcb_pkg::ST_IGNORED;
        end else if (phase == PH_POLL) begin
          res_next.status = sfcb_pkg::ST_RUNNING;
          if (send_try) begin
            idle_count_next = 16'd0;
            if (tx_empty) begin
              tx_re             = 1'b1;
              res_next.tx_valid = 1'b1;
              res_next.sel_tx   = 1'b1;
              tx_rd_next   = (tx_rd == TIW'(TX_DEPTH - 1)) ? '0 : tx_rd + TIW'(1);
              tx_fill_next = tx_fill - TFW'(1);
            end
          end
          if (rx_ready) begin
            idle_count_next = 16'd0;
            if (ctrl_char) begin
              partner_ok_next = (data_byte == sfcb_pkg::CH_XON);
            end else begin
              if (do_put) begin
                rx_we        = 1'b1;
                rx_wr_next   = (rx_wr == RIW'(RX_DEPTH - 1)) ? '0 : rx_wr + RIW'(1);
                rx_fill_next = fill_put;
              end
              // high-water: drop receive enable where the flow mode has one, and drain
              if (fill_put_ext >= hw) begin
                if (mode_rts) begin
                  rts_flag_next = 1'b0;
                end else if (mode_xon && rx_allowed) begin
                  pending_next    = PEND_XOFF;
                  rx_allowed_next = 1'b0;
                end
                phase_next      = PH_DRAIN;
                idle_count_next = 16'd0;
              end
            end
          end else begin
            idle_count_next = idle_inc;
            if (idle_inc >= idle_limit) begin
              phase_next      = PH_NONE;
              res_next.status = sfcb_pkg::ST_NO_ACT;
            end
          end
        end else if (phase == PH_DRAIN) begin
          res_next.status = sfcb_pkg::ST_RUNNING;
          if (rx_ready) begin
            idle_count_next = 16'd0;
            if (ctrl_char) begin
              partner_ok_next = (data_byte == sfcb_pkg::CH_XON);
            end else begin
              if (do_put) begin
                rx_we        = 1'b1;
                rx_wr_next   = (rx_wr == RIW'(RX_DEPTH - 1)) ? '0 : rx_wr + RIW'(1);
                rx_fill_next = fill_put;
              end
              if (fill_put_ext >= cap) begin
                phase_next      = PH_NONE;
                res_next.status = sfcb_pkg::ST_OVERFLOW;
              end
            end
          end else begin
            idle_count_next = idle_inc;
            if (idle_inc >= idle_limit) begin
              phase_next      = PH_NONE;
              res_next.status = sfcb_pkg::ST_FULL;
            end
          end
        end else begin
          phase_next      = PH_NONE;
          res_next.status = sfcb_pkg::ST_IGNORED;
        end
      end
    endcase

    res_next.rts      = rts_flag_next;
    res_next.rx_level = 9'(rx_fill_next);
    res_next.tx_level = 10'(tx_fill_next);

    // memory accesses only for an accepted word
    rx_we = rx_we && in_acc;
    rx_re = rx_re && in_acc;
    tx_we = tx_we && in_acc;
    tx_re = tx_re && in_acc;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_mode   <= sfcb_pkg::FLOW_MODE_RST;
      rx_capacity <= sfcb_pkg::RX_CAPACITY_RST;
      rx_reserve  <= sfcb_pkg::RX_RESERVE_RST;
      idle_limit  <= sfcb_pkg::IDLE_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        sfcb_pkg::CFG_FLOW_MODE:   flow_mode   <= cfg_data[1:0];
        sfcb_pkg::CFG_RX_CAPACITY: rx_capacity <= cfg_data[8:0];
        sfcb_pkg::CFG_RX_RESERVE:  rx_reserve  <= cfg_data[7:0];
        sfcb_pkg::CFG_IDLE_LIMIT:  idle_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wr      <= '0;
      rx_rd      <= '0;
      rx_fill    <= '0;
      tx_wr      <= '0;
      tx_rd      <= '0;
      tx_fill    <= '0;
      partner_ok <= 1'b1;
      rx_allowed <= 1'b1;
      rts_flag   <= 1'b0;
      phase      <= PH_NONE;
      idle_count <= 16'd0;
      pending    <= PEND_NONE;
      out_valid  <= 1'b0;
    end else begin
      if (in_acc) begin
        rx_wr      <= rx_wr_next;
        rx_rd      <= rx_rd_next;
        rx_fill    <= rx_fill_next;
        tx_wr      <= tx_wr_next;
        tx_rd      <= tx_rd_next;
        tx_fill    <= tx_fill_next;
        partner_ok <= partner_ok_next;
        rx_allowed <= rx_allowed_next;
        rts_flag   <= rts_flag_next;
        phase      <= phase_next;
        idle_count <= idle_count_next;
        pending    <= pending_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res <= res_next;
    end
  end

  `ASSERT_IMPLIES(a_rx_fill_bound, clk, rst, 1'b1, rx_fill <= RFW'(RX_DEPTH))
  `ASSERT_IMPLIES(a_tx_empty_ptrs, clk, rst, tx_fill == '0, tx_wr == tx_rd)
  `ASSERT_IMPLIES(a_sel_exclusive, clk, rst, out_valid, !(res.sel_tx && res.sel_rx))
  `ASSERT_IMPLIES(a_sel_tx_valid, clk, rst, out_valid && res.sel_tx, res.tx_valid)
  `ASSERT_NEXT(a_acc_gives_result, clk, rst, in_acc, out_valid)

endmodule

// ===== rtl/serial_flow_control_buffers.sv =====
// serial port buffer engine: transmit and receive rings with flow control
// a result word is valid in the cycle after its input word is accepted
// popped and sent bytes come from the ring read registered at the accepting edge
// throughput: one word per cycle, ring pointers sit in registers so no access waits
// a waiting result stalls the input only while the output register is held
// reset: synchronous, clears pointers, fills and session state, ring contents stay
`timescale 1ns / 1ps

module serial_flow_control_buffers #(
  parameter int RX_DEPTH = sfcb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = sfcb_pkg::TX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic        rx_ready,
  input  logic        tx_empty,
  input  logic        cts_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        rts_level,
  output logic [2:0]  status,
  output logic [7:0]  rx_byte_out,
  output logic [8:0]  rx_level,
  output logic [9:0]  tx_level
);

  localparam int RIW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TIW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  sfcb_pkg::result_t res;
  logic              rx_we, rx_re, tx_we, tx_re;
  logic [RIW-1:0]    rx_waddr, rx_raddr;
  logic [TIW-1:0]    tx_waddr, tx_raddr;
  logic [7:0]        rx_rdata, tx_rdata;

  sfcb_ctrl #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .data_byte (data_byte),
    .rx_ready  (rx_ready),
    .tx_empty  (tx_empty),
    .cts_level (cts_level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .rx_we     (rx_we),
    .rx_waddr  (rx_waddr),
    .rx_re     (rx_re),
    .rx_raddr  (rx_raddr),
    .tx_we     (tx_we),
    .tx_waddr  (tx_waddr),
    .tx_re     (tx_re),
    .tx_raddr  (tx_raddr)
  );

  // receive ring
  sfcb_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (data_byte),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  // transmit ring
  sfcb_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (data_byte),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  // result word: ring data joins the registered control fields
  assign tx_valid    = res.tx_valid;
  assign tx_byte     = res.sel_tx ? tx_rdata : res.tx_byte;
  assign rts_level   = res.rts;
  assign status      = res.status;
  assign rx_byte_out = res.sel_rx ? rx_rdata : 8'd0;
  assign rx_level    = res.rx_level;
  assign tx_level    = res.tx_level;

endmodule
